// ===== rtl/imhq_pkg.sv =====
package imhq_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned HANDLES  = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned HDL_W    = $clog2(HANDLES);

  localparam logic [1:0] ACT_INSERT     = 2'd0;
  localparam logic [1:0] ACT_DECREASE   = 2'd1;
  localparam logic [1:0] ACT_REMOVE     = 2'd2;
  localparam logic [1:0] ACT_REMOVE_ALT = 2'd3;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_LARGER  = 3'd4,
    ST_PRESENT = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_LOOKUP,
    FS_DEC_CHK,
    FS_RM_LOAD,
    FS_UP_CHK,
    FS_UP_EVAL,
    FS_DN_RD,
    FS_DN_EVAL,
    FS_WR_FINAL,
    FS_FIN
  } fsm_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  handle;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_handle;
    logic [31:0] out_key;
    status_e     status;
    logic [8:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [HDL_W-1:0]    handle;
  } slot_t;

endpackage

// ===== rtl/indexed_min_heap_queue.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | in_data_i  (in_item_t)
// out     | output    | out_valid_o/ out_stall_i| out_data_o (out_item_t)
//
// One transaction at a time: insert looks up the handle, then climbs level by level toward
// the root; decrease adds a key check before it climbs; remove loads the last entry into the
// root and sinks it level by level; a remove with one entry or on an empty queue skips the walk.
// Each level costs one slot memory read, then compare and write back.
// Reset clears the count and the handle valid bits at once; no clearing pass.
// A result waits in the output register; a new transaction is taken while it waits.
module indexed_min_heap_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  imhq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output imhq_pkg::out_item_t out_data_o
);
  import imhq_pkg::*;

  fsm_e state_q, state_d;

  slot_t            slot_mem [CAPACITY];
  logic [IDX_W-1:0] pos_mem  [HANDLES];
  logic [HANDLES-1:0] pos_vld_q;

  slot_t            rd_a_q, rd_b_q;
  logic [IDX_W-1:0] pos_rd_q;
  logic             pos_rd_vld_q;

  logic [CNT_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    at_q;
  slot_t               mv_q;
  logic [1:0]          act_q;
  logic [HDL_W-1:0]    res_h_q;
  logic [KEY_BITS-1:0] res_k_q;
  status_e             st_q;
  out_item_t           out_q;
  logic                out_valid_q;

  logic             slot_re, slot_we, pos_re, pos_we, clr_vld;
  logic [IDX_W-1:0] slot_ra_a, slot_ra_b, slot_wa, pos_wd;
  slot_t            slot_wd;
  logic [HDL_W-1:0] pos_ra, pos_wa;

  logic             accept, is_rm, out_free;
  logic [IDX_W+1:0] l_idx, r_idx;
  logic [IDX_W-1:0] up_idx, last_idx, best_idx;
  logic [CNT_W-1:0] pos_eff;
  logic             l_ok, r_ok, take_l, take_r, move, up_gt, dec_larger;
  logic [KEY_BITS-1:0] cur_key;
  slot_t            best_slot;

  assign accept     = in_valid_i && !in_stall_o;
  assign is_rm      = in_data_i.action[1];
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != FS_IDLE);

  assign l_idx    = {1'b0, at_q, 1'b1};
  assign r_idx    = l_idx + (IDX_W+2)'(1);
  assign up_idx   = (at_q - IDX_W'(1)) >> 1;
  assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
  assign pos_eff  = pos_rd_vld_q ? CNT_W'(pos_rd_q) : CNT_W'(CAPACITY);
  assign l_ok     = (IDX_W+2)'(cnt_q) > l_idx;
  assign r_ok     = (IDX_W+2)'(cnt_q) > r_idx;
  assign take_l   = l_ok && (rd_a_q.key < mv_q.key);
  assign cur_key  = take_l ? rd_a_q.key : mv_q.key;
  assign take_r   = r_ok && (rd_b_q.key < cur_key);
  assign move     = take_l || take_r;
  assign best_slot = take_r ? rd_b_q : rd_a_q;
  assign best_idx  = take_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
  assign up_gt      = rd_a_q.key > mv_q.key;
  assign dec_larger = mv_q.key > rd_a_q.key;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: begin
        if (in_valid_i) begin
          if (is_rm) state_d = (cnt_q == '0) ? FS_FIN : FS_RM_LOAD;
          else       state_d = FS_LOOKUP;
        end
      end
      FS_LOOKUP: begin
        if (act_q == ACT_INSERT) begin
          if (pos_eff < cnt_q || cnt_q == CNT_W'(CAPACITY)) state_d = FS_FIN;
          else state_d = FS_UP_CHK;
        end else begin
          state_d = (pos_eff >= cnt_q) ? FS_FIN : FS_DEC_CHK;
        end
      end
      FS_DEC_CHK:  state_d = dec_larger ? FS_FIN : FS_UP_CHK;
      FS_RM_LOAD:  state_d = (cnt_q == CNT_W'(1)) ? FS_FIN : FS_DN_RD;
      FS_UP_CHK:   state_d = (at_q == '0) ? FS_WR_FINAL : FS_UP_EVAL;
      FS_UP_EVAL:  state_d = up_gt ? FS_UP_CHK : FS_WR_FINAL;
      FS_DN_RD:    state_d = l_ok ? FS_DN_EVAL : FS_WR_FINAL;
      FS_DN_EVAL:  state_d = move ? FS_DN_RD : FS_WR_FINAL;
      FS_WR_FINAL: state_d = FS_FIN;
      FS_FIN:      state_d = out_free ? FS_IDLE : FS_FIN;
      default:     state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    slot_re   = 1'b0;
    slot_ra_a = '0;
    slot_ra_b = '0;
    slot_we   = 1'b0;
    slot_wa   = at_q;
    slot_wd   = mv_q;
    pos_re    = 1'b0;
    pos_ra    = in_data_i.handle;
    pos_we    = 1'b0;
    pos_wa    = mv_q.handle;
    pos_wd    = at_q;
    clr_vld   = 1'b0;
    case (state_q)
      FS_IDLE: begin
        slot_re   = accept && is_rm;
        slot_ra_b = last_idx;
        pos_re    = accept && !is_rm;
      end
      FS_LOOKUP: begin
        slot_re   = 1'b1;
        slot_ra_a = pos_rd_q;
      end
      FS_RM_LOAD: clr_vld = 1'b1;
      FS_UP_CHK: begin
        slot_re   = 1'b1;
        slot_ra_a = up_idx;
      end
      FS_UP_EVAL: begin
        slot_we = up_gt;
        slot_wd = rd_a_q;
        pos_we  = up_gt;
        pos_wa  = rd_a_q.handle;
      end
      FS_DN_RD: begin
        slot_re   = 1'b1;
        slot_ra_a = l_idx[IDX_W-1:0];
        slot_ra_b = r_idx[IDX_W-1:0];
      end
      FS_DN_EVAL: begin
        slot_we = move;
        slot_wd = best_slot;
        pos_we  = move;
        pos_wa  = best_slot.handle;
      end
      FS_WR_FINAL: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) begin
      rd_a_q <= slot_mem[slot_ra_a];
      rd_b_q <= slot_mem[slot_ra_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pos_re) begin
      pos_rd_q     <= pos_mem[pos_ra];
      pos_rd_vld_q <= pos_vld_q[pos_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      cnt_q       <= '0;
      pos_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pos_we) pos_vld_q[pos_wa] <= 1'b1;
      if (clr_vld) pos_vld_q[rd_a_q.handle] <= 1'b0;
      if (state_q == FS_LOOKUP && state_d == FS_UP_CHK && act_q == ACT_INSERT) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == FS_RM_LOAD) cnt_q <= cnt_q - CNT_W'(1);
      if (state_q == FS_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FS_IDLE: begin
        if (accept) begin
          act_q <= in_data_i.action;
          mv_q  <= '{key: in_data_i.key, handle: in_data_i.handle};
          if (is_rm && cnt_q == '0) begin
            st_q    <= ST_EMPTY;
            res_h_q <= '0;
            res_k_q <= '0;
          end else begin
            st_q    <= ST_OK;
            res_h_q <= in_data_i.handle;
            res_k_q <= in_data_i.key;
          end
        end
      end
      FS_LOOKUP: begin
        if (act_q == ACT_INSERT) begin
          at_q <= cnt_q[IDX_W-1:0];
          if (pos_eff < cnt_q) st_q <= ST_PRESENT;
          else if (cnt_q == CNT_W'(CAPACITY)) st_q <= ST_FULL;
        end else begin
          at_q <= pos_rd_q;
          if (pos_eff >= cnt_q) st_q <= ST_ABSENT;
        end
      end
      FS_DEC_CHK: if (dec_larger) st_q <= ST_LARGER;
      FS_RM_LOAD: begin
        res_h_q <= rd_a_q.handle;
        res_k_q <= rd_a_q.key;
        mv_q    <= rd_b_q;
        at_q    <= '0;
      end
      FS_UP_EVAL: if (up_gt) at_q <= up_idx;
      FS_DN_EVAL: if (move) at_q <= best_idx;
      FS_FIN: begin
        if (out_free) begin
          out_q.out_handle  <= res_h_q;
          out_q.out_key     <= res_k_q;
          out_q.status      <= st_q;
          out_q.entry_count <= cnt_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY)) else $error("count above capacity");
  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |-> (CNT_W'(slot_wa) < cnt_q)) else $error("slot write beyond fill");
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_EMPTY) |-> (out_q.entry_count == '0))
    else $error("empty status with entries");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_FIN && out_free) |=> out_valid_q) else $error("result dropped");
`endif

endmodule
